[rtl/core/srsh_pkg.sv]
// Package for the square root block: widths, derived sizes and sequencer states.
// No dependencies; imported by square_root_scan_and_heron, srsh_checker and tb_top.
`default_nettype none

package srsh_pkg;

   // Operand bits taken into account and fraction bits of the result
   localparam int IN_WIDTH  = 16;
   localparam int FRAC_BITS = 16;

   // Fixed port widths
   localparam int OPND_W = 16;
   localparam int ROOT_W = 24;

   // Floor root digits, one per pair of operand bits
   localparam int SQ_W   = (IN_WIDTH + 1) / 2;
   localparam int PAD_W  = 2 * SQ_W;
   // Divisor (k, then x1), partial remainder, dividend / quotient shifter
   localparam int DVSR_W = IN_WIDTH + FRAC_BITS;
   localparam int SUB_W  = DVSR_W + 1;
   localparam int DIVD_W = IN_WIDTH + 2 * FRAC_BITS;
   // First division only needs the quotient bits of operand * 2^FRAC_BITS
   localparam int DIV1_STEPS = IN_WIDTH + FRAC_BITS;
   localparam int CNT_W  = $clog2(DIVD_W);
   // Width for the final average, wide enough for the result port too
   localparam int SUM_W  = (DIVD_W + 1 > ROOT_W + 1) ? DIVD_W + 1 : ROOT_W + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SQRT   = 5'b00010,
      S_DIV1   = 5'b00100,
      S_DIV2   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

[rtl/core/square_root_scan_and_heron.sv]
// Square root of an unsigned integer in fixed point, two Heron steps from the floor root.
// Depends on srsh_pkg for widths and the sequencer state type.
`default_nettype none

// Usage
//   Request channel (req_valid / req_ready / req_operand): one unsigned operand per
//   request. req_ready is high only while the sequencer is idle.
//   Response channel (rsp_valid / rsp_ready / rsp_root / rsp_exact): one response per
//   request; rsp_root has FRAC_BITS fraction bits, rsp_exact flags a perfect square.
// Throughput
//   Perfect squares skip both divisions and go from the root digits straight to the
//   response. The single shared subtractor yields one root digit per cycle, then one
//   quotient bit per cycle for operand/k and for operand/x1. One request in flight at a
//   time; the next request is taken the cycle after the response is loaded.
// Stalls
//   The response sits in an output register until taken. A new request is accepted
//   while it waits; the sequencer then holds in its last state until the register is
//   free, so nothing is dropped.
// Reset
//   Synchronous, active high: sequencer to idle, response register empty.
module square_root_scan_and_heron (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [srsh_pkg::OPND_W-1:0] req_operand,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [srsh_pkg::ROOT_W-1:0]      rsp_root,
   output logic                             rsp_exact
);
   import srsh_pkg::*;

   state_type             state_ff,    state_in;
   logic [CNT_W-1:0]      cnt_ff,      cnt_in;
   logic [IN_WIDTH-1:0]   opnd_ff,     opnd_in;
   logic [SUB_W-1:0]      rem_ff,      rem_in;     // root remainder, then division remainder
   logic [SQ_W-1:0]       sq_ff,       sq_in;      // floor root, later k
   logic [DIVD_W-1:0]     dvd_ff,      dvd_in;     // operand bits out, quotient bits in
   logic [DVSR_W-1:0]     dvsr_ff,     dvsr_in;    // k, then x1
   logic                  exact_ff,    exact_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]     rsp_root_ff,  rsp_root_in;
   logic                  rsp_exact_ff, rsp_exact_in;

   // Shared subtract / compare unit
   logic [SUB_W-1:0]      sub_a, sub_b;
   logic [SUB_W:0]        sub_diff;
   logic                  sub_borrow;

   logic [SQ_W-1:0]       sq_step;
   logic [SUB_W-1:0]      rem_sq_step;
   logic [DIVD_W-1:0]     dvd_div_step;
   logic [DVSR_W:0]       x1_sum;
   logic [SUM_W-1:0]      avg_sum;
   logic [SUM_W-1:0]      exact_root;
   logic                  out_free;

   always_comb begin
      sub_a = {rem_ff[SUB_W-2:0], dvd_ff[DIVD_W-1]};
      sub_b = SUB_W'(dvsr_ff);
      if (state_ff == S_SQRT) begin
         sub_a = {rem_ff[SUB_W-3:0], dvd_ff[DIVD_W-1 -: 2]};
         sub_b = SUB_W'({sq_ff, 2'b01});
      end
   end

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[SUB_W];

   // One root digit: keep the trial subtraction when it does not borrow
   assign sq_step      = {sq_ff[SQ_W-2:0], ~sub_borrow};
   assign rem_sq_step  = sub_borrow ? sub_a : sub_diff[SUB_W-1:0];
   // One quotient bit shifted in at the bottom
   assign dvd_div_step = {dvd_ff[DIVD_W-2:0], ~sub_borrow};

   // x1 = (n/k + k) / 2, quotient of the first division is in the low bits
   assign x1_sum = {1'b0, dvd_div_step[DIV1_STEPS-1:0]}
                 + ((DVSR_W + 1)'(sq_ff) << FRAC_BITS);

   // root = (x1 + x2) / 2 for the Heron path, k << FRAC_BITS for exact squares
   assign avg_sum    = (SUM_W'(dvd_ff) + SUM_W'(dvsr_ff)) >> 1;
   assign exact_root = SUM_W'(sq_ff) << FRAC_BITS;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      opnd_in      = opnd_ff;
      rem_in       = rem_ff;
      sq_in        = sq_ff;
      dvd_in       = dvd_ff;
      dvsr_in      = dvsr_ff;
      exact_in     = exact_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_root_in  = rsp_root_ff;
      rsp_exact_in = rsp_exact_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               opnd_in  = IN_WIDTH'(req_operand);
               // operand left-aligned, padded to an even number of bits
               dvd_in   = DIVD_W'(PAD_W'(IN_WIDTH'(req_operand))) << (DIVD_W - PAD_W);
               rem_in   = '0;
               sq_in    = '0;
               cnt_in   = CNT_W'(SQ_W - 1);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            sq_in  = sq_step;
            rem_in = rem_sq_step;
            dvd_in = dvd_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               exact_in = (rem_sq_step == '0);
               if (rem_sq_step == '0) begin
                  state_in = S_FINISH;
               end else begin
                  // k is the floor root here; first division n * 2^F / k
                  dvsr_in  = DVSR_W'(sq_step);
                  rem_in   = '0;
                  dvd_in   = DIVD_W'(opnd_ff) << (2 * FRAC_BITS);
                  cnt_in   = CNT_W'(DIV1_STEPS - 1);
                  state_in = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            dvd_in = dvd_div_step;
            if (!sub_borrow) begin
               rem_in = sub_diff[SUB_W-1:0];
            end else begin
               rem_in = sub_a;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // x2 = n * 2^(2F) / x1, full-length division
               dvsr_in  = x1_sum[DVSR_W:1];
               rem_in   = '0;
               dvd_in   = DIVD_W'(opnd_ff) << (2 * FRAC_BITS);
               cnt_in   = CNT_W'(DIVD_W - 1);
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            dvd_in = dvd_div_step;
            if (!sub_borrow) begin
               rem_in = sub_diff[SUB_W-1:0];
            end else begin
               rem_in = sub_a;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_exact_in = exact_ff;
               rsp_root_in  = exact_ff ? exact_root[ROOT_W-1:0] : avg_sum[ROOT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      opnd_ff      <= opnd_in;
      rem_ff       <= rem_in;
      sq_ff        <= sq_in;
      dvd_ff       <= dvd_in;
      dvsr_ff      <= dvsr_in;
      exact_ff     <= exact_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_exact_ff <= rsp_exact_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = rsp_root_ff;
   assign rsp_exact = rsp_exact_ff;

`ifndef ASSERT_OFF
   // A response is only ever loaded from the finishing state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response loaded outside finishing state");

   // Exact roots carry no fraction bits
   a_exact_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exact_ff) |-> (rsp_root_ff[FRAC_BITS-1:0] == '0))
      else $error("exact root with fraction bits set");

   // Restoring division keeps the partial remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 || state_ff == S_DIV2) |-> (rem_ff < SUB_W'(dvsr_ff)))
      else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire

[bench/srsh_checker.sv]
// Response checker for square_root_scan_and_heron: watches both channels, predicts each root.
// Depends on srsh_pkg for widths; hands failure and progress counts to tb_top.
module srsh_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [srsh_pkg::OPND_W-1:0]   req_operand,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [srsh_pkg::ROOT_W-1:0]   rsp_root,
   input  logic                          rsp_exact,
   output int                            fail_count,
   output int                            open_count,
   output int                            checked_count,
   output int                            exact_count
);
   import srsh_pkg::*;

   typedef struct packed {
      logic [OPND_W-1:0] operand;
      logic [ROOT_W-1:0] root;
      logic              exact;
   } root_expect_type;

   root_expect_type pending_roots[$];

   initial begin
      fail_count    = 0;
      open_count    = 0;
      checked_count = 0;
      exact_count   = 0;
   end

   // floor root by scan, then two Heron steps from k = i-1 if not a square
   function automatic root_expect_type predict_root(input logic [OPND_W-1:0] operand);
      root_expect_type e;
      logic [63:0]     n, i, k, x1, x2, r;
      n = 64'(operand) & ((64'd1 << IN_WIDTH) - 64'd1);
      i = 64'd0;
      while (i * i < n) i++;
      if (i * i == n) begin
         r = i << FRAC_BITS;
         e.exact = 1'b1;
      end else begin
         k  = i - 64'd1;
         x1 = (((n << FRAC_BITS) / k) + (k << FRAC_BITS)) >> 1;
         x2 = (n << (2 * FRAC_BITS)) / x1;
         r  = (x1 + x2) >> 1;
         e.exact = 1'b0;
      end
      e.operand = operand;
      e.root    = r[ROOT_W-1:0];
      return e;
   endfunction

   always @(posedge clock) begin
      root_expect_type e;
      if (!reset) begin
         // compare before pushing: a new request never matches a response on the same edge
         if (rsp_valid && rsp_ready) begin
            if (pending_roots.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%0t: response with nothing outstanding: root=%h exact=%b",
                           $time, rsp_root, rsp_exact);
            end else begin
               e = pending_roots.pop_front();
               checked_count <= checked_count + 1;
               if (e.exact) exact_count <= exact_count + 1;
               if (rsp_root !== e.root || rsp_exact !== e.exact) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("%0t: operand %0d: root %h exact %b, expected root %h exact %b",
                              $time, e.operand, rsp_root, rsp_exact, e.root, e.exact);
               end
            end
         end
         if (req_valid && req_ready)
            pending_roots.push_back(predict_root(req_operand));
      end
      open_count <= pending_roots.size();
   end

endmodule

[bench/tb_top.sv]
// Testbench top for square_root_scan_and_heron: clock, reset, request stimulus and verdict.
// Depends on srsh_pkg and the srsh_checker module, which does all prediction and comparison.
module tb_top;
   import srsh_pkg::*;

   // cycles without any handshake before the run is declared hung; well above the
   // slowest correct request plus its gaps and stalls
   localparam int HANG_LIMIT = 2000;
   // tail after the last response, a little over the non-square latency
   localparam int TAIL_CYCLES = 100;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [OPND_W-1:0] req_operand = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [ROOT_W-1:0] rsp_root;
   logic              rsp_exact;

   int  fail_count, open_count, checked_count, exact_count;
   int  sent_count  = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  calm        = 1'b0;   // when set, neither side inserts gaps or stalls

   always #6 clock = ~clock;

   square_root_scan_and_heron i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_root    (rsp_root),
      .rsp_exact   (rsp_exact)
   );

   srsh_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_root      (rsp_root),
      .rsp_exact     (rsp_exact),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count),
      .exact_count   (exact_count)
   );

   // Response side: a fresh random stall, possibly none, is drawn after every response
   // taken, and now and then ready drops on its own so that stalls also land
   // while the block is still computing or idle.
   always @(posedge clock) begin
      int next_stall;
      if (reset) begin
         next_stall = 0;
      end else if (rsp_valid && rsp_ready) begin
         next_stall = calm ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
         next_stall = stall_left - 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         next_stall = $urandom_range(1, 5);
      end else begin
         next_stall = 0;
      end
      stall_left <= next_stall;
      rsp_ready  <= !reset && (next_stall == 0);
   end

   // Watchdog: counts edges with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d requests outstanding",
                  $time, HANG_LIMIT, open_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offers one request after a random gap and returns on the edge it is taken.
   // Valid is only lowered when a gap is drawn, so back-to-back requests keep it high.
   task automatic send_request(input logic [OPND_W-1:0] operand);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_operand <= operand;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Holds off until every outstanding request has been answered.
   // open_count is registered from the checker's queue, so a request taken on this edge is already seen.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   initial begin
      logic [OPND_W-1:0] directed[$];
      logic [OPND_W-1:0] operand;
      int                sel, base;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero and one, smallest non-squares, squares and their
      // neighbours, the largest square and the operands above it, bit patterns
      directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9,
                   16'd15, 16'd16, 16'd17, 16'd99, 16'd100, 16'd255, 16'd256,
                   16'd1024, 16'h5555, 16'hAAAA, 16'h8000, 16'd65024, 16'd65025,
                   16'd65026, 16'hFFFE, 16'hFFFF};
      foreach (directed[j]) send_request(directed[j]);
      drain();

      // Random phases: the first without gaps or stalls, the rest with both,
      // draining between phases so the sender also waits on an empty block
      for (int phase = 0; phase < 4; phase++) begin
         calm = (phase == 0);
         for (int n = 0; n < 207; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
               base    = $urandom_range(0, 255);
               operand = OPND_W'(base * base);
            end else if (sel < 4) begin
               base    = $urandom_range(1, 255);
               operand = $urandom_range(0, 1) ? OPND_W'(base * base + 1)
                                              : OPND_W'(base * base - 1);
            end else if (sel < 5) begin
               operand = OPND_W'($urandom_range(0, 15));
            end else begin
               operand = OPND_W'($urandom_range(0, 65535));
            end
            send_request(operand);
         end
         drain();
      end
      calm = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summary: %0d requests, %0d responses checked, %0d of them perfect squares;",
               sent_count, checked_count, exact_count);
      $display("directed edge operands plus random phases with and without idle gaps and stalls");
      if (fail_count == 0 && open_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, open_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
